/* src/ccc_pkg.sv */
// shared types, widths and register codes for the coin combination checker
`timescale 1ns / 1ps
package ccc_pkg;

  // fixed field widths
  localparam int VAL_W     = 20;
  localparam int TALLY_W   = 48;
  localparam int CNT_W     = 3;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_QTY   = 6;

  // parameter defaults
  localparam int DEF_MAX_DENOMS = 6;
  localparam int DEF_INDEX_BITS = 48;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DENOM0 = 3'd2;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RAD_GO,
    S_RAD_RUN,
    S_IDX_GO,
    S_IDX_RUN,
    S_ACC,
    S_ADD,
    S_FIN
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic div_rad;
    logic div_idx;
    logic take_digit;
    logic add_digit;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_busy;
    logic last_denom;
  } sts_t;

endpackage

/* src/ccc_in_if.sv */
// input item channel: combination index and clear flag
`timescale 1ns / 1ps
interface ccc_in_if import ccc_pkg::*; #(
  parameter int IDX_W = DEF_INDEX_BITS
);
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] combination_index;
  logic             clear_count;

  modport source (output valid, combination_index, clear_count, input ready);
  modport sink (input valid, combination_index, clear_count, output ready);
endinterface

/* src/ccc_out_if.sv */
// result item channel: match flag, running count and quantities
`timescale 1ns / 1ps
interface ccc_out_if import ccc_pkg::*;;
  logic               valid;
  logic               ready;
  logic               is_match;
  logic [TALLY_W-1:0] match_count;
  logic [VAL_W-1:0]   qty_0;
  logic [VAL_W-1:0]   qty_1;
  logic [VAL_W-1:0]   qty_2;
  logic [VAL_W-1:0]   qty_3;
  logic [VAL_W-1:0]   qty_4;
  logic [VAL_W-1:0]   qty_5;

  modport source (output valid, is_match, match_count, qty_0, qty_1, qty_2, qty_3, qty_4,
                  qty_5, input ready);
  modport sink (input valid, is_match, match_count, qty_0, qty_1, qty_2, qty_3, qty_4,
                qty_5, output ready);
endinterface

/* src/ccc_div.sv */
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module ccc_div import ccc_pkg::*; #(
  parameter int DIV_W = DEF_INDEX_BITS,
  parameter int CW    = $clog2(DEF_INDEX_BITS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [VAL_W:0]   divisor_i,
  input  logic [CW-1:0]    steps_i,
  output logic             busy_o,
  output logic [DIV_W-1:0] quot_o,
  output logic [VAL_W:0]   rem_o
);

  logic             run_q;
  logic [CW-1:0]    cnt_q;
  logic [DIV_W-1:0] dq_q;
  logic [VAL_W:0]   rem_q;
  logic [VAL_W:0]   dvs_q;
  logic [VAL_W+1:0] trial;
  logic [VAL_W+1:0] diff;
  logic             fits;

  // trial subtraction of the shifted partial remainder
  always_comb begin
    trial = {rem_q, dq_q[DIV_W-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = ~diff[VAL_W+1];
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= steps_i;
    end else if (run_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        run_q <= 1'b0;
      end
    end
  end

  // dividend shifts out at the top, quotient bits enter at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      dq_q  <= {dq_q[DIV_W-2:0], fits};
      rem_q <= fits ? diff[VAL_W:0] : trial[VAL_W:0];
    end
  end

  assign busy_o = run_q;
  assign quot_o = dq_q;
  assign rem_o  = rem_q;

endmodule

/* src/ccc_dp.sv */
// datapath: configuration, digit decode, weighted sum and match tally
`timescale 1ns / 1ps
module ccc_dp import ccc_pkg::*; #(
  parameter int MAX_DENOMS = DEF_MAX_DENOMS,
  parameter int IDX_W      = DEF_INDEX_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [VAL_W-1:0]     cfg_data_i,
  input  logic [IDX_W-1:0]     combination_index_i,
  input  logic                 clear_count_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic                 is_match_o,
  output logic [TALLY_W-1:0]   match_count_o,
  output logic [VAL_W-1:0]     qty_o [NUM_QTY]
);

  localparam int DIV_W  = (IDX_W > VAL_W) ? IDX_W : VAL_W;
  localparam int DCW    = $clog2(DIV_W + 1);
  localparam int DEN_IW = (MAX_DENOMS > 1) ? $clog2(MAX_DENOMS) : 1;
  localparam int TOT_W  = 2 * VAL_W + 3;

  logic [VAL_W-1:0]   target_q;
  logic [CNT_W-1:0]   count_q;
  logic [VAL_W-1:0]   denom_q [MAX_DENOMS];

  logic [IDX_W-1:0]   idx_q;
  logic               clr_q;
  logic [CNT_W-1:0]   used_q;
  logic [DEN_IW-1:0]  sel_q;
  logic [TOT_W-1:0]   total_q;
  logic [2*VAL_W-1:0] prod_q;
  logic [VAL_W-1:0]   qty_w_q [MAX_DENOMS];
  logic               match_q;
  logic [TALLY_W-1:0] tally_q;
  logic [VAL_W-1:0]   qty_out_q [MAX_DENOMS];

  logic [VAL_W-1:0]   d_cur;
  logic [CNT_W-1:0]   used_d;
  logic               div_start;
  logic [DIV_W-1:0]   div_dividend;
  logic [VAL_W:0]     div_divisor;
  logic [DCW-1:0]     div_steps;
  logic               div_busy;
  logic [DIV_W-1:0]   div_quot;
  logic [VAL_W:0]     div_rem;
  logic               match_d;
  logic [TALLY_W-1:0] tally_base;
  logic [TALLY_W-1:0] tally_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      count_q  <= CNT_W'(1);
      for (int k = 0; k < MAX_DENOMS; k++) begin
        denom_q[k] <= VAL_W'(1);
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_TARGET) begin
        target_q <= cfg_data_i;
      end
      if (cfg_idx_i == REG_COUNT) begin
        count_q <= cfg_data_i[CNT_W-1:0];
      end
      for (int k = 0; k < MAX_DENOMS; k++) begin
        if (cfg_idx_i == REG_DENOM0 + CFG_IDX_W'(k)) begin
          denom_q[k] <= cfg_data_i;
        end
      end
    end
  end

  // current denomination, zero read as one, and clamped count in use
  always_comb begin
    d_cur = (denom_q[sel_q] == '0) ? VAL_W'(1) : denom_q[sel_q];
    if (count_q == '0) begin
      used_d = CNT_W'(1);
    end else if (count_q > CNT_W'(MAX_DENOMS)) begin
      used_d = CNT_W'(MAX_DENOMS);
    end else begin
      used_d = count_q;
    end
  end

  // divider operands: radix = target / d, then index / (radix + 1)
  always_comb begin
    div_start = cmd_i.div_rad | cmd_i.div_idx;
    if (cmd_i.div_idx) begin
      div_dividend = DIV_W'(idx_q) << (DIV_W - IDX_W);
      div_divisor  = {1'b0, div_quot[VAL_W-1:0]} + 1'b1;
      div_steps    = DCW'(IDX_W);
    end else begin
      div_dividend = DIV_W'(target_q) << (DIV_W - VAL_W);
      div_divisor  = {1'b0, d_cur};
      div_steps    = DCW'(VAL_W);
    end
  end

  ccc_div #(
    .DIV_W (DIV_W),
    .CW    (DCW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .steps_i    (div_steps),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // per-item working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      idx_q   <= combination_index_i;
      clr_q   <= clear_count_i;
      used_q  <= used_d;
      sel_q   <= '0;
      total_q <= '0;
      for (int k = 0; k < MAX_DENOMS; k++) begin
        qty_w_q[k] <= '0;
      end
    end else if (cmd_i.take_digit) begin
      idx_q          <= div_quot[IDX_W-1:0];
      qty_w_q[sel_q] <= div_rem[VAL_W-1:0];
      prod_q         <= div_rem[VAL_W-1:0] * d_cur;
    end else if (cmd_i.add_digit) begin
      total_q <= total_q + TOT_W'(prod_q);
      if (!sts_o.last_denom) begin
        sel_q <= sel_q + 1'b1;
      end
    end
  end

  assign sts_o.div_busy   = div_busy;
  assign sts_o.last_denom = (CNT_W'(sel_q) + CNT_W'(1)) == used_q;

  // match check and saturating tally, clear applied first
  always_comb begin
    match_d    = total_q == TOT_W'(target_q);
    tally_base = clr_q ? '0 : tally_q;
    tally_d    = tally_base;
    if (match_d && (tally_base != '1)) begin
      tally_d = tally_base + 1'b1;
    end
  end

  // running tally doubles as the result count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q <= '0;
    end else if (cmd_i.finish) begin
      tally_q <= tally_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      match_q   <= match_d;
      qty_out_q <= qty_w_q;
    end
  end

  assign is_match_o    = match_q;
  assign match_count_o = tally_q;

  // quantities beyond the built denominations read as zero
  always_comb begin
    for (int k = 0; k < NUM_QTY; k++) begin
      qty_o[k] = '0;
      if (k < MAX_DENOMS) begin
        qty_o[k] = qty_out_q[k];
      end
    end
  end

  // tally only grows between clears
  a_tally_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && !clr_q |=> tally_q >= $past(tally_q))
    else $error("match tally went down without a clear");

endmodule

/* src/ccc_ctrl.sv */
// controller: sequences the digit decode and the result hand-off
`timescale 1ns / 1ps
module ccc_ctrl import ccc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic out_ready_i,
  output logic out_valid_o,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = ~out_valid_q | out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (in_valid_i) state_d = S_RAD_GO;
      S_RAD_GO:  state_d = S_RAD_RUN;
      S_RAD_RUN: if (!sts_i.div_busy) state_d = S_IDX_GO;
      S_IDX_GO:  state_d = S_IDX_RUN;
      S_IDX_RUN: if (!sts_i.div_busy) state_d = S_ACC;
      S_ACC:     state_d = S_ADD;
      S_ADD:     state_d = sts_i.last_denom ? S_FIN : S_RAD_GO;
      S_FIN:     if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      S_RAD_GO:  cmd_o.div_rad    = 1'b1;
      S_IDX_GO:  cmd_o.div_idx    = 1'b1;
      S_ACC:     cmd_o.take_digit = 1'b1;
      S_ADD:     cmd_o.add_digit  = 1'b1;
      S_FIN:     cmd_o.finish     = out_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // divider picks up every start
  a_div_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_rad || cmd_o.div_idx |=> sts_i.div_busy)
    else $error("divider did not start");

  // no division left running between items
  a_div_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !sts_i.div_busy)
    else $error("divider busy while idle");

  // a finished item is always presented
  a_finish_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_q)
    else $error("result not presented after finish");

endmodule

/* src/coin_combination_checker.sv */
// top level: coin combination checker
//
//  channel    dir  handshake              payload
//  item_i     in   valid / ready          combination_index, clear_count
//  result_o   out  valid / ready          is_match, match_count, qty_0..qty_5
//  cfg        in   cfg_we_i, no stall     cfg_idx_i, cfg_data_i
//
// One item at a time. Each denomination in use runs two divisions on the shared
// one-bit-per-cycle divider, first for the radix and then for the index.
// A new item is taken while the previous result still waits; a stalled result
// holds the finished item in the last state until the output register frees up.
// Reset clears the control state and the tally and loads the register defaults.
`timescale 1ns / 1ps
module coin_combination_checker import ccc_pkg::*; #(
  parameter int MAX_DENOMS  = DEF_MAX_DENOMS,
  parameter int INDEX_BITS  = DEF_INDEX_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ccc_in_if.sink               item_i,
  ccc_out_if.source            result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [VAL_W-1:0]     cfg_data_i
);

  cmd_t             cmd;
  sts_t             sts;
  logic [VAL_W-1:0] qty [NUM_QTY];

  // sequencer
  ccc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // datapath
  ccc_dp #(
    .MAX_DENOMS (MAX_DENOMS),
    .IDX_W      (INDEX_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .combination_index_i (item_i.combination_index),
    .clear_count_i       (item_i.clear_count),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .is_match_o          (result_o.is_match),
    .match_count_o       (result_o.match_count),
    .qty_o               (qty)
  );

  // quantity fields
  assign result_o.qty_0 = qty[0];
  assign result_o.qty_1 = qty[1];
  assign result_o.qty_2 = qty[2];
  assign result_o.qty_3 = qty[3];
  assign result_o.qty_4 = qty[4];
  assign result_o.qty_5 = qty[5];

endmodule

/* test/coin_combination_checker_tb.sv */
// self-checking testbench for the coin combination checker: directed cases, random combinations
`timescale 1ns / 1ps
module coin_combination_checker_tb;
  import ccc_pkg::*;

  localparam int IDX_W            = DEF_INDEX_BITS;
  localparam int SETTLE_CYCLES    = 8;
  localparam int TAIL_CYCLES      = 500;
  localparam int LONG_HOLD_CYCLES = 3000;
  localparam int RANDOM_UNTIL     = 1400;
  localparam int STEADY_ITEMS     = 150;
  localparam int TIMEOUT_NS       = 20000000;
  localparam logic [127:0] IDX_MAX = (128'd1 << IDX_W) - 128'd1;

  typedef struct packed {
    logic                          is_match;
    logic [TALLY_W-1:0]            match_count;
    logic [NUM_QTY-1:0][VAL_W-1:0] qty;
  } combo_outcome_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [VAL_W-1:0]     cfg_data_i;

  ccc_in_if  item_if ();
  ccc_out_if result_if ();

  coin_combination_checker u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_if),
    .result_o   (result_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // mirror of the register file and the tally
  logic [VAL_W-1:0]              coin_target;
  logic [CNT_W-1:0]              coin_count;
  logic [NUM_QTY-1:0][VAL_W-1:0] coin_denom;
  logic [TALLY_W-1:0]            match_tally;

  combo_outcome_t predicted_outcomes [$];

  bit idling_on        = 1'b1;
  bit hold_off_request = 1'b0;
  int items_sent       = 0;
  int results_seen     = 0;
  int matches_seen     = 0;
  int config_count     = 0;
  int fail_count       = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("FAIL coin_combination_checker");
    $finish;
  end

  // denominations in use, out-of-range counts clamped
  function automatic int denoms_in_use();
    if (coin_count == '0) return 1;
    if (coin_count > NUM_QTY) return NUM_QTY;
    return int'(coin_count);
  endfunction

  // a zero denomination behaves as 1
  function automatic logic [63:0] coin_value(input int i);
    return (coin_denom[i] == '0) ? 64'd1 : 64'(coin_denom[i]);
  endfunction

  // decode one index, weigh the coins and update the tally
  function automatic combo_outcome_t check_combination(input logic [IDX_W-1:0] idx,
                                                       input logic clr);
    combo_outcome_t   res;
    logic [63:0]      rest;
    logic [63:0]      radix;
    logic [63:0]      digit;
    logic [63:0]      total;
    int               used;
    res   = '0;
    rest  = 64'(idx);
    total = '0;
    used  = denoms_in_use();
    if (clr) match_tally = '0;
    for (int i = 0; i < used; i++) begin
      radix      = 64'(coin_target) / coin_value(i) + 64'd1;
      digit      = rest % radix;
      rest       = rest / radix;
      res.qty[i] = VAL_W'(digit);
      total      = total + digit * coin_value(i);
    end
    res.is_match = (total == 64'(coin_target));
    if (res.is_match && match_tally != '1) match_tally = match_tally + 1'b1;
    res.match_count = match_tally;
    return res;
  endfunction

  // build an index from quantities that aim at the target, sometimes one coin off
  function automatic logic [IDX_W-1:0] make_combination();
    logic [NUM_QTY-1:0][63:0] q;
    logic [63:0]  rem;
    logic [127:0] acc;
    logic [127:0] place;
    logic [127:0] maxk;
    int           used;
    int           k;
    used = denoms_in_use();
    q    = '0;
    rem  = 64'(coin_target);
    for (int i = used - 1; i >= 1; i--) begin
      q[i] = ($urandom_range(0, 3) == 0) ? 64'd0 : 64'($urandom_range(0, 32'(rem / coin_value(i))));
      rem  = rem - q[i] * coin_value(i);
    end
    q[0] = rem / coin_value(0);
    if ($urandom_range(0, 3) == 0) begin
      k = $urandom_range(0, used - 1);
      if (q[k] != 0) q[k] = q[k] - 64'd1;
      else q[k] = q[k] + 64'd1;
    end
    acc   = '0;
    place = 128'd1;
    for (int i = 0; i < used; i++) begin
      acc   = acc + 128'(q[i]) * place;
      place = place * (128'(coin_target) / 128'(coin_value(i)) + 128'd1);
    end
    // leftover above the last digit is dropped, so add whole spans now and then
    if (place <= IDX_MAX && acc <= IDX_MAX && $urandom_range(0, 3) == 0) begin
      maxk = (IDX_MAX - acc) / place;
      acc  = acc + place * (128'({$urandom, $urandom}) % (maxk + 128'd1));
    end
    return IDX_W'(acc);
  endfunction

  // well-formed combinations most of the time, raw indexes otherwise
  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(0, 9) < 7) return make_combination();
    case ($urandom_range(0, 3))
      0:       return IDX_W'({$urandom, $urandom});
      1:       return IDX_W'($urandom_range(0, 1000));
      2:       return IDX_W'({$urandom, $urandom}) >> $urandom_range(0, IDX_W - 1);
      default: return ($urandom_range(0, 1) == 1) ? '1 : '0;
    endcase
  endfunction

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (want !== got) begin
      $display("%0t result %0d: %s expected %0h got %0h", $time, results_seen, name,
               want, got);
      fail_count++;
    end
  endfunction

  // result checker
  combo_outcome_t observed;
  combo_outcome_t predicted;
  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready) begin
      observed.is_match    = result_if.is_match;
      observed.match_count = result_if.match_count;
      observed.qty[0]      = result_if.qty_0;
      observed.qty[1]      = result_if.qty_1;
      observed.qty[2]      = result_if.qty_2;
      observed.qty[3]      = result_if.qty_3;
      observed.qty[4]      = result_if.qty_4;
      observed.qty[5]      = result_if.qty_5;
      if (predicted_outcomes.size() == 0) begin
        $display("%0t result %0d: expected none got match %0b count %0h", $time,
                 results_seen, observed.is_match, observed.match_count);
        fail_count++;
      end else begin
        predicted = predicted_outcomes.pop_front();
        compare_field("is_match", 64'(predicted.is_match), 64'(observed.is_match));
        compare_field("match_count", 64'(predicted.match_count), 64'(observed.match_count));
        for (int i = 0; i < NUM_QTY; i++)
          compare_field($sformatf("qty_%0d", i), 64'(predicted.qty[i]), 64'(observed.qty[i]));
      end
      results_seen++;
      if (observed.is_match) matches_seen++;
    end
  end

  // result receiver: random stall bursts, or one long hold-off on request
  initial begin : result_receiver
    int stall_left;
    stall_left      = 0;
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_request) begin
        stall_left       = LONG_HOLD_CYCLES;
        hold_off_request = 1'b0;
      end else if (stall_left == 0 && idling_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 16);
      end
      if (stall_left > 0) begin
        result_if.ready <= 1'b0;
        stall_left--;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // offer one item, predict its outcome once taken
  task automatic send_item(input logic [IDX_W-1:0] idx, input logic clr);
    if (idling_on && $urandom_range(0, 7) == 0) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    item_if.valid             <= 1'b1;
    item_if.combination_index <= idx;
    item_if.clear_count       <= clr;
    do @(posedge clk_i); while (!item_if.ready);
    predicted_outcomes.push_back(check_combination(idx, clr));
    items_sent++;
  endtask

  // stop offering and let every outstanding result drain
  task automatic wait_for_results();
    item_if.valid <= 1'b0;
    while (predicted_outcomes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_TARGET: coin_target = data;
      REG_COUNT:  coin_count  = data[CNT_W-1:0];
      default:    coin_denom[idx - REG_DENOM0] = data;
    endcase
    @(posedge clk_i);
  endtask

  // write every register while the block is idle
  task automatic program_config(input logic [VAL_W-1:0] target,
                                input logic [VAL_W-1:0] count_word,
                                input logic [NUM_QTY-1:0][VAL_W-1:0] coins);
    wait_for_results();
    write_reg(REG_TARGET, target);
    write_reg(REG_COUNT, count_word);
    for (int i = 0; i < NUM_QTY; i++)
      write_reg(REG_DENOM0 + CFG_IDX_W'(i), coins[i]);
    cfg_we_i <= 1'b0;
    config_count++;
  endtask

  // random setting, small targets and few denominations favoured
  task automatic program_random_config();
    logic [VAL_W-1:0]              target;
    logic [CNT_W-1:0]              cnt;
    logic [NUM_QTY-1:0][VAL_W-1:0] coins;
    int                            r;
    case ($urandom_range(0, 9))
      0:            target = '0;
      1, 2, 3:      target = VAL_W'($urandom_range(1, 40));
      4, 5, 6, 7:   target = VAL_W'($urandom_range(41, 5000));
      8:            target = VAL_W'($urandom_range(5001, 20'hFFFFE));
      default:      target = '1;
    endcase
    r = $urandom_range(0, 19);
    if (r == 0) cnt = '0;
    else if (r == 1) cnt = '1;
    else if (r < 8) cnt = 3'd1;
    else if (r < 13) cnt = 3'd2;
    else if (r < 16) cnt = 3'd3;
    else cnt = CNT_W'($urandom_range(4, NUM_QTY));
    for (int i = 0; i < NUM_QTY; i++) begin
      r = $urandom_range(0, 15);
      if (r == 0) coins[i] = '0;
      else if (r == 1) coins[i] = '1;
      else if (r < 6) coins[i] = VAL_W'(1);
      else coins[i] = VAL_W'($urandom_range(1, 32'(target) + 32'(target) / 4 + 1));
    end
    // only the low bits of the count register matter
    program_config(target, {(VAL_W - CNT_W)'($urandom), cnt}, coins);
  endtask

  // defaults after reset: target 0 with one coin of 1 matches every index
  task automatic test_reset_defaults();
    send_item('0, 1'b0);
    send_item('1, 1'b0);
    send_item(IDX_W'({$urandom, $urandom}), 1'b1);
  endtask

  // hand-picked combinations and each special case
  task automatic test_directed_combinations();
    // denominations listed from the sixth down to the first
    // radices 31, 7, 4 for coins 1, 5, 10 towards 30
    program_config(20'd30, 20'd3, {20'h0ABCD, 20'h12345, 20'h54321, 20'd10, 20'd5, 20'd1});
    send_item(IDX_W'(0), 1'b0);
    send_item(IDX_W'(496), 1'b0);
    send_item(IDX_W'(30), 1'b0);
    send_item(IDX_W'(470), 1'b0);
    send_item(IDX_W'(1), 1'b0);
    send_item('1, 1'b0);
    // zero count and zero denomination both behave as 1, index wraps past the digit
    program_config(20'd7, 20'd0, {20'd9, 20'd9, 20'd9, 20'd9, 20'd9, 20'd0});
    send_item(IDX_W'(7), 1'b0);
    send_item(IDX_W'(15), 1'b0);
    send_item(IDX_W'(3), 1'b1);
    // count above the maximum clamps to six, last coin zero
    program_config(20'd3, 20'hFFFFF, {20'd0, 20'd1, 20'd1, 20'd1, 20'd1, 20'd1});
    send_item(IDX_W'(3072), 1'b0);
    send_item('1, 1'b0);
    send_item(IDX_W'(9), 1'b0);
    // largest target with a single coin of 1
    program_config(20'hFFFFF, 20'd1, {20'd1, 20'd1, 20'd1, 20'd1, 20'd1, 20'd1});
    send_item(IDX_W'(20'hFFFFF), 1'b0);
    send_item('1, 1'b1);
    // largest denomination beside a coin of 1
    program_config(20'hFFFFF, 20'd2, {20'd1, 20'd1, 20'd1, 20'd1, 20'd1, 20'hFFFFF});
    send_item(IDX_W'(1), 1'b0);
    send_item(IDX_W'(21'h1FFFFE), 1'b0);
    send_item(IDX_W'(0), 1'b0);
  endtask

  // long result stall while items keep coming, then a full pause
  task automatic test_output_backpressure();
    program_config(20'd12, 20'd1, {20'd1, 20'd1, 20'd1, 20'd1, 20'd1, 20'd3});
    hold_off_request = 1'b1;
    repeat (10) send_item(pick_index(), $urandom_range(0, 15) == 0);
    wait_for_results();
  endtask

  task automatic test_random_combinations();
    idling_on = 1'b1;
    while (items_sent < RANDOM_UNTIL) begin
      program_random_config();
      repeat ($urandom_range(30, 90)) send_item(pick_index(), $urandom_range(0, 15) == 0);
    end
  endtask

  // back-to-back traffic with no idling on either side
  task automatic test_steady_stream();
    program_random_config();
    idling_on = 1'b0;
    repeat (STEADY_ITEMS) send_item(pick_index(), $urandom_range(0, 15) == 0);
  endtask

  // main sequence
  initial begin
    rst_ni                    = 1'b0;
    cfg_we_i                  = 1'b0;
    cfg_idx_i                 = '0;
    cfg_data_i                = '0;
    item_if.valid             = 1'b0;
    item_if.combination_index = '0;
    item_if.clear_count       = 1'b0;
    coin_target               = '0;
    coin_count                = CNT_W'(1);
    for (int i = 0; i < NUM_QTY; i++) coin_denom[i] = VAL_W'(1);
    match_tally               = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_directed_combinations();
    test_output_backpressure();
    test_random_combinations();
    test_steady_stream();

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (predicted_outcomes.size() != 0) fail_count++;
    $display("covered %0d items over %0d register settings, %0d matching combinations",
             items_sent, config_count, matches_seen);
    $display("checked %0d results, %0d field mismatches", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("PASS coin_combination_checker");
    end else begin
      $display("FAIL coin_combination_checker");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/ccc_pkg.sv
src/ccc_in_if.sv
src/ccc_out_if.sv
src/ccc_div.sv
src/ccc_dp.sv
src/ccc_ctrl.sv
src/coin_combination_checker.sv
test/coin_combination_checker_tb.sv
